// File: hdl/itcf_pkg.sv
// itcf_pkg: shared widths, register map, config and CORDIC result types,
// and the arctangent table of the tilt filter.
// No dependencies.
package itcf_pkg;

    // CORDIC datapath width: 17-bit samples scaled by 256 plus gain growth
    localparam int CW   = 28;
    localparam int AW   = 32;   // angle width, 2^32 units per turn
    localparam int MA_W = 33;   // shared multiplier operand a
    localparam int MB_W = 25;   // shared multiplier operand b
    localparam int P_W  = MA_W + MB_W;
    localparam int ATAN_N = 24;

    localparam logic signed [MB_W-1:0] MAG_RECIP = 25'sd39797;   // round(65536/K)
    localparam logic signed [P_W-1:0]  RND_8     = 58'sd128;
    localparam logic signed [P_W-1:0]  RND_16    = 58'sd32768;
    localparam logic [23:0] GAIN_RST  = 24'd23301;
    localparam logic [15:0] ALPHA_RST = 16'd64225;

    typedef enum logic [2:0] {
        REG_AX_OFF = 3'd0,
        REG_AY_OFF = 3'd1,
        REG_AZ_OFF = 3'd2,
        REG_GX_OFF = 3'd3,
        REG_GY_OFF = 3'd4,
        REG_GAIN   = 3'd5,
        REG_ALPHA  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] ax_off;
        logic signed [15:0] ay_off;
        logic signed [15:0] az_off;
        logic signed [15:0] gx_off;
        logic signed [15:0] gy_off;
        logic        [23:0] gain;
        logic        [15:0] alpha;
    } t_cfg;

    typedef struct packed {
        logic                 done;
        logic [AW-1:0]        angle;
        logic signed [CW-1:0] mag;
    } t_cordic_res;

    function automatic logic [AW-1:0] atan_entry(input logic [4:0] idx);
        logic [AW-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/itcf_regs.sv
// itcf_regs: APB configuration registers (offsets, step gain, blend alpha).
// Depends on itcf_pkg.
module itcf_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output itcf_pkg::t_cfg    o_cfg
);

    itcf_pkg::t_cfg r_cfg;
    itcf_pkg::t_reg_idx idx;

    assign idx    = itcf_pkg::t_reg_idx'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ax_off <= '0;
            r_cfg.ay_off <= '0;
            r_cfg.az_off <= '0;
            r_cfg.gx_off <= '0;
            r_cfg.gy_off <= '0;
            r_cfg.gain   <= itcf_pkg::GAIN_RST;
            r_cfg.alpha  <= itcf_pkg::ALPHA_RST;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                itcf_pkg::REG_AX_OFF: r_cfg.ax_off <= pwdata[15:0];
                itcf_pkg::REG_AY_OFF: r_cfg.ay_off <= pwdata[15:0];
                itcf_pkg::REG_AZ_OFF: r_cfg.az_off <= pwdata[15:0];
                itcf_pkg::REG_GX_OFF: r_cfg.gx_off <= pwdata[15:0];
                itcf_pkg::REG_GY_OFF: r_cfg.gy_off <= pwdata[15:0];
                itcf_pkg::REG_GAIN:   r_cfg.gain   <= pwdata[23:0];
                itcf_pkg::REG_ALPHA:  r_cfg.alpha  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            itcf_pkg::REG_AX_OFF: prdata = {16'd0, r_cfg.ax_off};
            itcf_pkg::REG_AY_OFF: prdata = {16'd0, r_cfg.ay_off};
            itcf_pkg::REG_AZ_OFF: prdata = {16'd0, r_cfg.az_off};
            itcf_pkg::REG_GX_OFF: prdata = {16'd0, r_cfg.gx_off};
            itcf_pkg::REG_GY_OFF: prdata = {16'd0, r_cfg.gy_off};
            itcf_pkg::REG_GAIN:   prdata = {8'd0, r_cfg.gain};
            itcf_pkg::REG_ALPHA:  prdata = {16'd0, r_cfg.alpha};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// File: hdl/itcf_cordic.sv
// itcf_cordic: iterative vectoring CORDIC, one micro-rotation per cycle.
// Returns atan2-style angle (2^32 per turn) and K*|v|. Depends on itcf_pkg.
module itcf_cordic #(
    parameter int STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [itcf_pkg::CW-1:0] i_x,
    input  logic signed [itcf_pkg::CW-1:0] i_y,
    output itcf_pkg::t_cordic_res         o_res
);

    localparam int NSTEP = (STEPS < itcf_pkg::ATAN_N) ? STEPS : itcf_pkg::ATAN_N;
    localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NSTEP - 1);

    logic signed [itcf_pkg::CW-1:0] r_x, r_y, xs, ys;
    logic [itcf_pkg::AW-1:0]        r_z, atan_v;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_busy, r_done, r_zero;

    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_v = itcf_pkg::atan_entry(5'(r_cnt));

    assign o_res.done  = r_done;
    assign o_res.angle = r_zero ? '0 : r_z;
    assign o_res.mag   = r_zero ? '0 : r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // one-cycle pulse after the last micro-rotation
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    // left half plane: pre-rotate by half a turn
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= 32'h80000000;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y < 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

// File: hdl/itcf_mul.sv
// itcf_mul: shared signed multiplier with a registered product.
// Depends on itcf_pkg.
module itcf_mul (
    input  logic                             i_clk,
    input  logic signed [itcf_pkg::MA_W-1:0] i_a,
    input  logic signed [itcf_pkg::MB_W-1:0] i_b,
    output logic signed [itcf_pkg::P_W-1:0]  o_p
);

    logic signed [itcf_pkg::P_W-1:0] r_p;

    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

endmodule

// File: hdl/imu_tilt_complementary_filter.sv
// Roll/pitch complementary filter: CORDIC accel angles plus gyro integration.
// Each accepted beat takes two passes of the shared CORDIC and five products on the one shared
// multiplier; the input stalls until the result is loaded, and an unclaimed result holds the next.
// Reset (synchronous, active low) clears the estimates to zero, restores
// the default configuration and empties the result register.
module imu_tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_roll,
    output logic signed [15:0] o_pitch,
    output logic signed [15:0] o_accel_roll,
    output logic signed [15:0] o_accel_pitch
);

    typedef enum logic [3:0] {
        S_IDLE, S_CR1, S_MAG_MUL, S_MAG_ADD, S_CR2,
        S_RG_MUL, S_RG_ADD, S_RB_MUL, S_RB_ADD,
        S_PG_MUL, S_PG_ADD, S_PB_MUL, S_PB_ADD, S_FINAL
    } t_state;

    localparam int CW = itcf_pkg::CW;
    localparam int AW = itcf_pkg::AW;

    t_state                r_state;
    itcf_pkg::t_cfg        cfg;
    itcf_pkg::t_cordic_res cor;

    logic signed [16:0]    ax_c, ay_c, az_c, gx_c, gy_c;
    logic signed [16:0]    r_ax, r_gx, r_gy;
    logic signed [17:0]    nax;
    logic signed [CW-1:0]  r_mag, cor_x, cor_y, magc;
    logic                  cor_start, in_accept;
    logic [AW-1:0]         r_acc_roll, r_acc_pitch, r_est_roll, r_est_pitch;
    logic [AW-1:0]         d_roll, d_pitch, g_inc, b_inc;
    logic [16:0]           beta;
    logic signed [itcf_pkg::MA_W-1:0] mul_a;
    logic signed [itcf_pkg::MB_W-1:0] mul_b;
    logic signed [itcf_pkg::P_W-1:0]  mul_p, sum8, sum16;
    logic                  r_out_valid;
    logic [15:0]           r_roll, r_pitch, r_accel_roll, r_accel_pitch;
    logic [AW-1:0]         rnd_roll, rnd_pitch, rnd_aroll, rnd_apitch;

    itcf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    itcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .o_res   (cor)
    );

    itcf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // offset-corrected samples, exact in 17 bits
    assign ax_c = {i_accel_x[15], i_accel_x} - {cfg.ax_off[15], cfg.ax_off};
    assign ay_c = {i_accel_y[15], i_accel_y} - {cfg.ay_off[15], cfg.ay_off};
    assign az_c = {i_accel_z[15], i_accel_z} - {cfg.az_off[15], cfg.az_off};
    assign gx_c = {i_gyro_x[15], i_gyro_x} - {cfg.gx_off[15], cfg.gx_off};
    assign gy_c = {i_gyro_y[15], i_gyro_y} - {cfg.gy_off[15], cfg.gy_off};

    assign nax   = -{r_ax[16], r_ax};
    assign sum8  = mul_p + itcf_pkg::RND_8;
    assign sum16 = mul_p + itcf_pkg::RND_16;
    assign magc  = sum16[CW+15:16];
    assign g_inc = sum8[AW+7:8];
    assign b_inc = sum16[AW+15:16];
    assign beta  = 17'h10000 - {1'b0, cfg.alpha};

    assign d_roll  = r_acc_roll - r_est_roll;
    assign d_pitch = r_acc_pitch - r_est_pitch;

    // roll pass starts on the accepted beat, pitch pass after the gain fix-up
    assign cor_start = in_accept || (r_state == S_MAG_ADD);
    always_comb begin
        if (r_state == S_MAG_ADD) begin
            cor_x = magc;
            cor_y = {{(CW-26){nax[17]}}, nax, 8'd0};
        end else begin
            cor_x = {{(CW-25){ay_c[16]}}, ay_c, 8'd0};
            cor_y = {{(CW-25){az_c[16]}}, az_c, 8'd0};
        end
    end

    always_comb begin
        unique case (r_state)
            S_MAG_MUL: begin
                mul_a = {{(itcf_pkg::MA_W-CW){r_mag[CW-1]}}, r_mag};
                mul_b = itcf_pkg::MAG_RECIP;
            end
            S_RG_MUL: begin
                mul_a = {{(itcf_pkg::MA_W-17){r_gx[16]}}, r_gx};
                mul_b = {1'b0, cfg.gain};
            end
            S_PG_MUL: begin
                mul_a = {{(itcf_pkg::MA_W-17){r_gy[16]}}, r_gy};
                mul_b = {1'b0, cfg.gain};
            end
            S_RB_MUL: begin
                mul_a = {d_roll[AW-1], d_roll};
                mul_b = {8'd0, beta};
            end
            S_PB_MUL: begin
                mul_a = {d_pitch[AW-1], d_pitch};
                mul_b = {8'd0, beta};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd_roll   = r_est_roll + 32'h8000;
    assign rnd_pitch  = r_est_pitch + 32'h8000;
    assign rnd_aroll  = r_acc_roll + 32'h8000;
    assign rnd_apitch = r_acc_pitch + 32'h8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_est_roll  <= '0;
            r_est_pitch <= '0;
        end else begin
            // the final state reloads the result register itself
            if (r_out_valid && !i_out_stall && (r_state != S_FINAL)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_ax    <= ax_c;
                        r_gx    <= gx_c;
                        r_gy    <= gy_c;
                        r_state <= S_CR1;
                    end
                end
                S_CR1: begin
                    if (cor.done) begin
                        r_acc_roll <= cor.angle;
                        r_mag      <= cor.mag;
                        r_state    <= S_MAG_MUL;
                    end
                end
                S_MAG_MUL: r_state <= S_MAG_ADD;
                S_MAG_ADD: r_state <= S_CR2;
                S_CR2: begin
                    if (cor.done) begin
                        r_acc_pitch <= cor.angle;
                        r_state     <= S_RG_MUL;
                    end
                end
                S_RG_MUL: r_state <= S_RG_ADD;
                S_RG_ADD: begin
                    r_est_roll <= r_est_roll + g_inc;
                    r_state    <= S_RB_MUL;
                end
                S_RB_MUL: r_state <= S_RB_ADD;
                S_RB_ADD: begin
                    r_est_roll <= r_est_roll + b_inc;
                    r_state    <= S_PG_MUL;
                end
                S_PG_MUL: r_state <= S_PG_ADD;
                S_PG_ADD: begin
                    r_est_pitch <= r_est_pitch + g_inc;
                    r_state     <= S_PB_MUL;
                end
                S_PB_MUL: r_state <= S_PB_ADD;
                S_PB_ADD: begin
                    r_est_pitch <= r_est_pitch + b_inc;
                    r_state     <= S_FINAL;
                end
                S_FINAL: begin
                    // hold here only while the previous beat is still unclaimed
                    if (!r_out_valid || !i_out_stall) begin
                        r_roll        <= rnd_roll[31:16];
                        r_pitch       <= rnd_pitch[31:16];
                        r_accel_roll  <= rnd_aroll[31:16];
                        r_accel_pitch <= rnd_apitch[31:16];
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_roll        = r_roll;
    assign o_pitch       = r_pitch;
    assign o_accel_roll  = r_accel_roll;
    assign o_accel_pitch = r_accel_pitch;

`ifndef ASSERT_OFF
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor.done |-> (r_state == S_CR1 || r_state == S_CR2))
        else $error("CORDIC finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINAL))
        else $error("result loaded outside the final state");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_start |-> (r_state == S_IDLE || r_state == S_MAG_ADD))
        else $error("CORDIC started from an unexpected state");
`endif

endmodule

// File: verif/imu_tilt_complementary_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for imu_tilt_complementary_filter: APB register setup, sample beats
// with random bursts and output stalls, predicted roll/pitch compared per field.
// Depends on hdl/itcf_pkg.sv (register indexes) and the DUT.
module imu_tilt_complementary_filter_tb;

    localparam int          CORDIC_ITERS = 16;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 60;
    localparam longint      MAG_SCALE    = 39797;
    localparam logic [23:0] DEF_GAIN     = 24'd23301;
    localparam logic [15:0] DEF_ALPHA    = 16'd64225;
    localparam logic [2:0]  REG_UNUSED   = 3'd7;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } t_imu_sample;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] accel_roll;
        logic signed [15:0] accel_pitch;
    } t_tilt_angles;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_BURSTY} t_stall_mode;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [4:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic signed [15:0] accel_x   = '0;
    logic signed [15:0] accel_y   = '0;
    logic signed [15:0] accel_z   = '0;
    logic signed [15:0] gyro_x    = '0;
    logic signed [15:0] gyro_y    = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] accel_roll;
    logic signed [15:0] accel_pitch;

    imu_tilt_complementary_filter #(.CORDIC_STEPS(CORDIC_ITERS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .i_gyro_x      (gyro_x),
        .i_gyro_y      (gyro_y),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_roll        (roll),
        .o_pitch       (pitch),
        .o_accel_roll  (accel_roll),
        .o_accel_pitch (accel_pitch)
    );

    always #10 i_clk = ~i_clk;

    // arctangent of 2^-i, 2^32 units per turn
    logic [31:0] atan_turn [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // shadow of the register file and the two kept angles
    logic signed [15:0] m_ax_off, m_ay_off, m_az_off, m_gx_off, m_gy_off;
    logic [23:0]        m_gain;
    logic [15:0]        m_alpha;
    logic [31:0]        roll_est, pitch_est;

    t_tilt_angles pending_angles[$];
    int           samples_sent   = 0;
    int           angles_checked = 0;
    int           mismatch_cnt   = 0;
    int           settings_cnt   = 0;
    int           cycle_cnt      = 0;
    int           burst_left     = 0;
    int           stall_hold     = 0;
    bit           sender_idles   = 1'b0;
    t_stall_mode  stall_mode     = STALL_NONE;

    // vectoring CORDIC; returns the angle of (x,y), mag gets the scaled length
    function automatic logic [31:0] cordic_turn(input longint x_in, input longint y_in,
                                                output longint mag);
        longint      x, y, xs, ys;
        logic [31:0] z;
        x   = x_in;
        y   = y_in;
        z   = '0;
        mag = 0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_turn[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_turn[i];
            end
        end
        mag = x;
        return z;
    endfunction

    // gyro step, then pull toward the accel angle by (1 - alpha) of the wrapped error
    function automatic logic [31:0] advance_est(input logic [31:0] est, input longint rate,
                                                input logic [31:0] acc);
        longint      gyro_inc, diff, blend_inc;
        logic [31:0] e, raw;
        gyro_inc  = (longint'(m_gain) * rate + 128) >>> 8;
        e         = est + gyro_inc[31:0];
        raw       = acc - e;
        diff      = longint'($signed(raw));
        blend_inc = ((65536 - longint'(m_alpha)) * diff + 32768) >>> 16;
        return e + blend_inc[31:0];
    endfunction

    function automatic logic signed [15:0] to_out_angle(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h8000;
        return t[31:16];
    endfunction

    function automatic t_tilt_angles predict_angles(input t_imu_sample s);
        longint       ax, ay, az, gx, gy, mag, mag2, magc;
        logic [31:0]  a_roll, a_pitch;
        t_tilt_angles r;
        ax      = longint'(s.ax) - longint'(m_ax_off);
        ay      = longint'(s.ay) - longint'(m_ay_off);
        az      = longint'(s.az) - longint'(m_az_off);
        gx      = longint'(s.gx) - longint'(m_gx_off);
        gy      = longint'(s.gy) - longint'(m_gy_off);
        a_roll  = cordic_turn(ay * 256, az * 256, mag);
        magc    = (mag * MAG_SCALE + 32768) >>> 16;
        a_pitch = cordic_turn(magc, -ax * 256, mag2);
        roll_est  = advance_est(roll_est, gx, a_roll);
        pitch_est = advance_est(pitch_est, gy, a_pitch);
        r.roll        = to_out_angle(roll_est);
        r.pitch       = to_out_angle(pitch_est);
        r.accel_roll  = to_out_angle(a_roll);
        r.accel_pitch = to_out_angle(a_pitch);
        return r;
    endfunction

    function automatic t_imu_sample mk(input int ax, input int ay, input int az,
                                       input int gx, input int gy);
        t_imu_sample s;
        s.ax = ax[15:0];
        s.ay = ay[15:0];
        s.az = az[15:0];
        s.gx = gx[15:0];
        s.gy = gy[15:0];
        return s;
    endfunction

    function automatic logic signed [15:0] rand_near(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] rand_corner();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // half full-range noise, the rest plausible motion or field corners
    function automatic t_imu_sample rand_sample();
        t_imu_sample s;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            s.ax = 16'($urandom);
            s.ay = 16'($urandom);
            s.az = 16'($urandom);
            s.gx = 16'($urandom);
            s.gy = 16'($urandom);
        end else if (kind < 8) begin
            s.ax = rand_near(18000);
            s.ay = rand_near(18000);
            s.az = rand_near(18000);
            s.gx = rand_near(3000);
            s.gy = rand_near(3000);
        end else begin
            s.ax = rand_corner();
            s.ay = rand_corner();
            s.az = rand_corner();
            s.gx = rand_corner();
            s.gy = rand_corner();
        end
        return s;
    endfunction

    function automatic logic [31:0] sx16(input logic signed [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    task automatic reset_shadow();
        m_ax_off  = '0;
        m_ay_off  = '0;
        m_az_off  = '0;
        m_gx_off  = '0;
        m_gy_off  = '0;
        m_gain    = DEF_GAIN;
        m_alpha   = DEF_ALPHA;
        roll_est  = '0;
        pitch_est = '0;
    endtask

    // two-phase APB write; block must be idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            itcf_pkg::REG_AX_OFF: m_ax_off = val[15:0];
            itcf_pkg::REG_AY_OFF: m_ay_off = val[15:0];
            itcf_pkg::REG_AZ_OFF: m_az_off = val[15:0];
            itcf_pkg::REG_GX_OFF: m_gx_off = val[15:0];
            itcf_pkg::REG_GY_OFF: m_gy_off = val[15:0];
            itcf_pkg::REG_GAIN:   m_gain   = val[23:0];
            itcf_pkg::REG_ALPHA:  m_alpha  = val[15:0];
            default:              ;
        endcase
    endtask

    task automatic send_sample(input t_imu_sample s);
        in_valid <= 1'b1;
        accel_x  <= s.ax;
        accel_y  <= s.ay;
        accel_z  <= s.az;
        gyro_x   <= s.gx;
        gyro_y   <= s.gy;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_angles.push_back(predict_angles(s));
        samples_sent++;
        if (sender_idles) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                burst_left = $urandom_range(1, 6);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
    endtask

    // output beat check against the oldest prediction
    always @(posedge i_clk) begin
        t_tilt_angles exp_a;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_angles.size() == 0) begin
                $error("unexpected result beat: roll %0d pitch %0d", roll, pitch);
                mismatch_cnt++;
            end else begin
                exp_a = pending_angles.pop_front();
                angles_checked++;
                if (roll !== exp_a.roll) begin
                    $error("roll: expected %0d, got %0d", exp_a.roll, roll);
                    mismatch_cnt++;
                end
                if (pitch !== exp_a.pitch) begin
                    $error("pitch: expected %0d, got %0d", exp_a.pitch, pitch);
                    mismatch_cnt++;
                end
                if (accel_roll !== exp_a.accel_roll) begin
                    $error("accel_roll: expected %0d, got %0d", exp_a.accel_roll, accel_roll);
                    mismatch_cnt++;
                end
                if (accel_pitch !== exp_a.accel_pitch) begin
                    $error("accel_pitch: expected %0d, got %0d",
                           exp_a.accel_pitch, accel_pitch);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    out_stall  <= ~out_stall;
                    stall_hold <= out_stall ? $urandom_range(0, 15) : $urandom_range(1, 40);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_angles.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_level_and_gravity();
        send_sample(mk(0, 0, 0, 0, 0));                    // zero vector
        send_sample(mk(0, 0, 16384, 100, -100));           // level
        send_sample(mk(16384, 0, 0, 0, 0));                // gravity along +x
        send_sample(mk(-16384, 0, 0, 0, 0));               // gravity along -x
        send_sample(mk(0, 32767, 0, 0, 0));
        send_sample(mk(0, 0, -16384, 0, 0));               // upside down
        send_sample(mk(0, -32768, -32768, 0, 0));
        send_sample(mk(32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768));
        wait_drained();
    endtask

    task automatic test_alpha_zero();
        write_reg(itcf_pkg::REG_ALPHA, 32'd0);
        settings_cnt++;
        send_sample(mk(1000, -2000, 15000, 32767, -32768));
        send_sample(mk(-5000, 12000, -9000, 0, 0));
        send_sample(mk(0, 0, 0, -32768, 32767));
        wait_drained();
    endtask

    // large gain and almost pure gyro: estimates run around the circle
    task automatic test_gyro_wrap();
        write_reg(itcf_pkg::REG_GAIN, 32'h00FF_FFFF);
        write_reg(itcf_pkg::REG_ALPHA, 32'h0000_FFFF);
        settings_cnt++;
        send_sample(mk(0, 0, 16384, 32767, 32767));
        send_sample(mk(0, 0, 16384, 32767, -32768));
        send_sample(mk(0, 0, 16384, -32768, -32768));
        send_sample(mk(0, 0, 16384, 32767, 32767));
        wait_drained();
    endtask

    task automatic test_offset_extremes();
        write_reg(itcf_pkg::REG_AX_OFF, sx16(16'sd32767));
        write_reg(itcf_pkg::REG_AY_OFF, sx16(16'sd32767));
        write_reg(itcf_pkg::REG_AZ_OFF, sx16(16'sd32767));
        write_reg(itcf_pkg::REG_GX_OFF, sx16(16'sd32767));
        write_reg(itcf_pkg::REG_GY_OFF, sx16(16'sd32767));
        write_reg(itcf_pkg::REG_GAIN, 32'd0);
        write_reg(itcf_pkg::REG_ALPHA, {16'h0000, DEF_ALPHA});
        settings_cnt++;
        send_sample(mk(-32768, -32768, -32768, -32768, -32768));
        send_sample(mk(32767, -32768, 0, 32767, 0));
        wait_drained();
        write_reg(itcf_pkg::REG_AX_OFF, sx16(-16'sd32768));
        write_reg(itcf_pkg::REG_AY_OFF, sx16(-16'sd32768));
        write_reg(itcf_pkg::REG_AZ_OFF, sx16(-16'sd32768));
        write_reg(itcf_pkg::REG_GX_OFF, sx16(-16'sd32768));
        write_reg(itcf_pkg::REG_GY_OFF, sx16(-16'sd32768));
        write_reg(itcf_pkg::REG_GAIN, {8'h00, DEF_GAIN});
        settings_cnt++;
        send_sample(mk(32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-32768, 32767, -32768, 0, 32767));
        wait_drained();
        // unmapped address: nothing may change
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(mk(100, 200, 300, 400, 500));
        wait_drained();
    endtask

    function automatic logic signed [15:0] pick_offset();
        case ($urandom_range(0, 3))
            0:       return 16'sd0;
            1:       return rand_near(600);
            2:       return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
        endcase
    endfunction

    task automatic randomize_settings();
        logic [31:0] gain_v, alpha_v;
        case ($urandom_range(0, 4))
            0:       gain_v = 32'd0;
            1:       gain_v = 32'h00FF_FFFF;
            2:       gain_v = {8'h00, DEF_GAIN};
            default: gain_v = $urandom_range(0, 32'h00FF_FFFF);
        endcase
        case ($urandom_range(0, 5))
            0:       alpha_v = 32'd0;
            1:       alpha_v = 32'h0000_FFFF;
            2:       alpha_v = {16'h0000, DEF_ALPHA};
            3:       alpha_v = $urandom_range(60000, 65535);
            default: alpha_v = $urandom_range(0, 65535);
        endcase
        write_reg(itcf_pkg::REG_AX_OFF, sx16(pick_offset()));
        write_reg(itcf_pkg::REG_AY_OFF, sx16(pick_offset()));
        write_reg(itcf_pkg::REG_AZ_OFF, sx16(pick_offset()));
        write_reg(itcf_pkg::REG_GX_OFF, sx16(pick_offset()));
        write_reg(itcf_pkg::REG_GY_OFF, sx16(pick_offset()));
        write_reg(itcf_pkg::REG_GAIN, gain_v);
        write_reg(itcf_pkg::REG_ALPHA, alpha_v);
        settings_cnt++;
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            randomize_settings();
            // first phase runs with no idling on either side
            sender_idles = (p != 0) && (p % 4 != 3);
            case (p % 3)
                0:       stall_mode <= (p == 0) ? STALL_NONE : STALL_BURSTY;
                1:       stall_mode <= STALL_SPARSE;
                default: stall_mode <= STALL_BURSTY;
            endcase
            burst_left = $urandom_range(1, 6);
            for (int n = 0; n < per_phase; n++) send_sample(rand_sample());
            wait_drained();
        end
        stall_mode   <= STALL_NONE;
        sender_idles = 1'b0;
    endtask

    initial begin
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_level_and_gravity();
        test_alpha_zero();
        test_gyro_wrap();
        test_offset_extremes();
        test_random_phases(10, 125);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d samples sent over %0d register settings, %0d results checked",
                 samples_sent, settings_cnt, angles_checked);
        $display("directed: zero vector, vertical gravity, alpha zero, gyro wrap, offsets");
        if (mismatch_cnt == 0 && pending_angles.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (pending_angles.size() != 0)
                $error("%0d expected results never arrived", pending_angles.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/itcf_pkg.sv
hdl/itcf_regs.sv
hdl/itcf_cordic.sv
hdl/itcf_mul.sv
hdl/imu_tilt_complementary_filter.sv
verif/imu_tilt_complementary_filter_tb.sv
